// ===== rtl/core/bcc_pkg.sv =====
`default_nettype none

package bcc_pkg;

    localparam int MAX_DICE    = 32;
    localparam int MAX_FACES   = 32;
    localparam int MAX_SUM     = 256;
    localparam int COUNT_WIDTH = 64;

    // field widths of the request and response
    localparam int FACES_W  = 6;
    localparam int DICE_W   = 6;
    localparam int TARGET_W = 9;

    localparam int ROW_DEPTH = MAX_SUM + 1;
    localparam int ADDR_W    = $clog2(ROW_DEPTH);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // one row entry: count plus sticky overflow flag
    typedef struct packed {
        logic                   over;
        logic [COUNT_WIDTH-1:0] count;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    // read token handed from the issue stage to the accumulate stage
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              final_sum;
        logic              virt;
        logic              virt_one;
        logic              bank;
        logic [ADDR_W-1:0] waddr;
    } t_tok;

    function automatic t_entry sat_add(input t_entry a, input t_entry b);
        logic [COUNT_WIDTH:0] sum;
        t_entry               res;
        sum       = {1'b0, a.count} + {1'b0, b.count};
        res.over  = a.over | b.over | sum[COUNT_WIDTH];
        res.count = res.over ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bcc_if.sv =====
`default_nettype none

interface bcc_req_if;
    import bcc_pkg::*;

    logic                valid;
    logic                ready;
    logic [FACES_W-1:0]  faces;
    logic [DICE_W-1:0]   dice;
    logic [TARGET_W-1:0] target;

    modport source (output valid, output faces, output dice, output target, input ready);
    modport sink   (input valid, input faces, input dice, input target, output ready);
endinterface

interface bcc_rsp_if;
    import bcc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] ways;
    logic                   saturated;

    modport source (output valid, output ways, output saturated, input ready);
    modport sink   (input valid, input ways, input saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bounded_composition_counter.sv =====
`default_nettype none

// Counts the ordered ways that `dice` dice with faces 1..`faces` add up to
// `target`, one request transaction in, one response transaction out. Counts
// saturate at 2^64-1 and then `saturated` is set. Requests with a field out
// of range (faces > 32, dice > 32, target > 256) answer ways = 0. The rows
// of the recurrence live in two 257 x 65 bit synchronous memories used
// ping-pong: one holds the row of the previous die, the other takes the new
// row. Each cycle one entry of the previous row is read and folded into a
// saturating accumulator; the single read port of the previous row sets the
// pace of a run. The response turns valid in the same cycle as the next
// request can be taken. Trivial requests (no dice, zero faces, zero
// target, out of range) skip the run and go straight to the result. No
// clearing pass is needed: the row of die zero is produced by logic, and
// every entry that a later die reads was written by the die before it.
// A new request is taken as soon as the previous result has moved into
// the output register.
module bounded_composition_counter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bcc_req_if.sink    i_req,
    bcc_rsp_if.source  o_rsp
);
    import bcc_pkg::*;

    // control state
    t_state               r_state, n_state;
    logic [FACES_W-1:0]   r_faces, n_faces;
    logic [DICE_W-1:0]    r_dice, n_dice;
    logic [TARGET_W-1:0]  r_target, n_target;
    logic [DICE_W-1:0]    r_i, n_i;         // current die, 1-based
    logic [TARGET_W-1:0]  r_j, n_j;         // sum being built
    logic [FACES_W-1:0]   r_k, n_k;         // face being added
    logic                 r_bank, n_bank;   // memory holding the previous row

    // row memories
    t_entry               r_mem_a [ROW_DEPTH];
    t_entry               r_mem_b [ROW_DEPTH];
    t_entry               r_rd_a;
    t_entry               r_rd_b;

    // accumulate stage
    t_tok                 r_tok, n_tok;
    t_entry               r_acc, n_acc;
    t_entry               r_res, n_res;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [COUNT_WIDTH-1:0] r_out_ways, n_out_ways;
    logic                   r_out_sat, n_out_sat;

    logic                 req_fire;
    logic                 req_bad;
    logic                 last_k;
    logic                 last_j;
    logic [ADDR_W-1:0]    rd_addr;
    t_entry               operand;
    logic                 wr_en;

    assign req_fire = i_req.valid && i_req.ready;
    assign req_bad  = (32'(i_req.faces) > MAX_FACES) || (32'(i_req.dice) > MAX_DICE) ||
                      (32'(i_req.target) > MAX_SUM);

    // issue stage: address j-k of the previous row
    assign last_k  = (r_k == r_faces) || (TARGET_W'(r_k) == r_j);
    assign last_j  = (r_j == r_target);
    assign rd_addr = ADDR_W'(r_j - TARGET_W'(r_k));

    // accumulate stage operand: die zero row and entry zero come from logic
    always_comb begin
        if (r_tok.virt) begin
            operand.over  = 1'b0;
            operand.count = COUNT_WIDTH'(r_tok.virt_one);
        end else begin
            operand = r_tok.bank ? r_rd_b : r_rd_a;
        end
        n_acc = r_tok.first ? operand : sat_add(r_acc, operand);
    end

    assign wr_en = r_tok.valid && r_tok.last;

    always_comb begin
        n_state     = r_state;
        n_faces     = r_faces;
        n_dice      = r_dice;
        n_target    = r_target;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_bank      = r_bank;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_ways  = r_out_ways;
        n_out_sat   = r_out_sat;

        n_tok           = '0;
        n_tok.first     = (r_k == FACES_W'(1));
        n_tok.last      = last_k;
        n_tok.final_sum = last_k && last_j && (r_i == r_dice);
        n_tok.virt      = (r_i == DICE_W'(1)) || (rd_addr == '0);
        n_tok.virt_one  = (r_i == DICE_W'(1)) && (rd_addr == '0);
        n_tok.bank      = r_bank;
        n_tok.waddr     = ADDR_W'(r_j);

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_faces  = i_req.faces;
                    n_dice   = i_req.dice;
                    n_target = i_req.target;
                    n_i      = DICE_W'(1);
                    n_j      = TARGET_W'(1);
                    n_k      = FACES_W'(1);
                    n_bank   = 1'b0;
                    n_res    = '0;
                    if (req_bad) begin
                        n_state = ST_RESULT;
                    end else if (i_req.dice == '0) begin
                        // no dice: one way to reach zero, none otherwise
                        n_res.count = COUNT_WIDTH'(i_req.target == '0);
                        n_state     = ST_RESULT;
                    end else if (i_req.faces == '0 || i_req.target == '0) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                n_tok.valid = 1'b1;
                if (!last_k) begin
                    n_k = r_k + FACES_W'(1);
                end else begin
                    n_k = FACES_W'(1);
                    if (!last_j) begin
                        n_j = r_j + TARGET_W'(1);
                    end else begin
                        n_j = TARGET_W'(1);
                        if (r_i == r_dice) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_i    = r_i + DICE_W'(1);
                            n_bank = ~r_bank;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                // final sum leaves the accumulate stage this cycle
                if (r_tok.valid && r_tok.last && r_tok.final_sum) begin
                    n_res   = n_acc;
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ways  = r_res.over ? COUNT_MAX : r_res.count;
                    n_out_sat   = r_res.over;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tok       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tok       <= n_tok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_faces    <= n_faces;
        r_dice     <= n_dice;
        r_target   <= n_target;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_bank     <= n_bank;
        r_res      <= n_res;
        r_out_ways <= n_out_ways;
        r_out_sat  <= n_out_sat;
        if (r_tok.valid) begin
            r_acc <= n_acc;
        end
    end

    // new row goes to the memory that is not being read
    always_ff @(posedge i_clk) begin
        if (wr_en && r_tok.bank) begin
            r_mem_a[r_tok.waddr] <= n_acc;
        end
        r_rd_a <= r_mem_a[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !r_tok.bank) begin
            r_mem_b[r_tok.waddr] <= n_acc;
        end
        r_rd_b <= r_mem_b[rd_addr];
    end

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.ways      = r_out_ways;
    assign o_rsp.saturated = r_out_sat;

`ifndef ASSERT_OFF
    // the accumulate stage only carries reads of an item in progress
    a_tok_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok.valid |-> (r_state == ST_RUN || r_state == ST_DRAIN))
        else $error("read token outside of a running item");

    // row entry zero is never written; for every die after the first its zero comes from logic
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_tok.waddr != '0))
        else $error("write to row entry zero");

    // an accepted request always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state != ST_IDLE))
        else $error("accepted request left the block idle");

    // a saturated response reports the maximum count
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |-> (r_out_ways == COUNT_MAX))
        else $error("saturated response without maximum count");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_bounded_composition_counter.sv =====
`timescale 1ns / 100ps

module tb_bounded_composition_counter;
    import bcc_pkg::*;

    localparam int N_DIRECTED   = 24;
    localparam int RANDOM_ITEMS = 76;
    // small random requests stay below this total to keep the run short
    localparam int SMALL_SUM    = 48;
    // idle cycles after the last response
    localparam int SETTLE_CYCLES = 16;

    // one expected response together with the request that caused it
    typedef struct {
        int unsigned            faces;
        int unsigned            dice;
        int unsigned            target;
        logic [COUNT_WIDTH-1:0] ways;
        logic                   saturated;
    } t_dice_result;

    // directed table row: expected value typed in only where it is obvious
    typedef struct {
        int unsigned            faces;
        int unsigned            dice;
        int unsigned            target;
        bit                     known;
        logic [COUNT_WIDTH-1:0] ways;
        logic                   saturated;
    } t_stim_row;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // faces dice target known ways sat
        '{ 6,  0,   0, 1, 1, 0},  // no dice, zero target
        '{ 6,  0,   5, 1, 0, 0},  // no dice, nonzero target
        '{ 0,  0,   0, 1, 1, 0},  // no dice even with zero faces
        '{32,  0, 256, 1, 0, 0},
        '{ 0,  3,   5, 1, 0, 0},  // zero faces with dice
        '{ 0, 32, 256, 1, 0, 0},
        '{ 6,  3,   0, 1, 0, 0},  // zero target with dice
        '{32, 32,   0, 1, 0, 0},
        '{33,  2,   5, 1, 0, 0},  // faces out of range
        '{ 6, 33,   5, 1, 0, 0},  // dice out of range
        '{ 6,  2, 257, 1, 0, 0},  // target out of range
        '{63, 63, 511, 1, 0, 0},  // every field bit set
        '{ 1,  1,   1, 1, 1, 0},
        '{ 6,  1,   6, 1, 1, 0},
        '{ 6,  2,   7, 1, 6, 0},
        '{ 6,  2,  13, 1, 0, 0},  // above the largest reachable total
        '{32,  1,  32, 1, 1, 0},
        '{ 1, 32,  32, 1, 1, 0},
        '{32,  2,  64, 1, 1, 0},
        '{32, 32,  32, 1, 1, 0},  // only all ones reaches the minimum
        '{ 6,  3,  10, 0, 0, 0},
        '{10,  5,  27, 0, 0, 0},
        '{32, 32, 256, 0, 0, 0},  // largest request the block accepts
        '{24, 18, 225, 0, 0, 0}   // count far beyond 64 bits
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bcc_req_if req_bus ();
    bcc_rsp_if rsp_bus ();

    bounded_composition_counter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #2 i_clk = ~i_clk;

    // responses still owed by the block, oldest first
    t_dice_result pending_results [$];
    int unsigned  mismatch_count = 0;
    // sender burst state
    int unsigned  burst_left = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // one saturating step of the recurrence, bit COUNT_WIDTH is the sticky overflow
    function automatic logic [COUNT_WIDTH:0] add_clamped(input logic [COUNT_WIDTH:0] a,
                                                        input logic [COUNT_WIDTH:0] b);
        logic [COUNT_WIDTH:0] s;
        if (a[COUNT_WIDTH] || b[COUNT_WIDTH]) return {1'b1, COUNT_MAX};
        s = {1'b0, a[COUNT_WIDTH-1:0]} + {1'b0, b[COUNT_WIDTH-1:0]};
        if (s[COUNT_WIDTH]) return {1'b1, COUNT_MAX};
        return s;
    endfunction

    // number of ordered throws of `dice` dice with faces 1..`faces` summing to `target`
    function automatic t_dice_result count_dice_ways(input int unsigned faces,
                                                     input int unsigned dice,
                                                     input int unsigned target);
        logic [COUNT_WIDTH:0] prev_row [0:MAX_SUM];
        logic [COUNT_WIDTH:0] next_row [0:MAX_SUM];
        t_dice_result         res;
        res.faces     = faces;
        res.dice      = dice;
        res.target    = target;
        res.ways      = '0;
        res.saturated = 1'b0;
        // rejected request answers zero
        if (faces > MAX_FACES || dice > MAX_DICE || target > MAX_SUM) return res;
        foreach (prev_row[j]) prev_row[j] = '0;
        prev_row[0] = (COUNT_WIDTH+1)'(1);
        for (int unsigned d = 1; d <= dice; d++) begin
            foreach (next_row[j]) next_row[j] = '0;
            for (int unsigned j = 1; j <= target; j++) begin
                for (int unsigned k = 1; k <= faces && k <= j; k++) begin
                    next_row[j] = add_clamped(next_row[j], prev_row[j-k]);
                end
            end
            prev_row = next_row;
        end
        res.saturated = prev_row[target][COUNT_WIDTH];
        res.ways      = prev_row[target][COUNT_WIDTH-1:0];
        return res;
    endfunction

    // drive one request transaction, entered and left at a falling edge
    task automatic send_request(input t_dice_result exp);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_bus.valid  <= 1'b1;
        req_bus.faces  <= exp.faces[FACES_W-1:0];
        req_bus.dice   <= exp.dice[DICE_W-1:0];
        req_bus.target <= exp.target[TARGET_W-1:0];
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        pending_results.push_back(exp);
        @(negedge i_clk);
    endtask

    // reset and stimulus
    initial begin
        t_dice_result exp;
        int unsigned  f;
        int unsigned  d;
        int unsigned  t;
        int unsigned  pick;
        int unsigned  hi;

        req_bus.valid  = 1'b0;
        req_bus.faces  = '0;
        req_bus.dice   = '0;
        req_bus.target = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed_rows[n]) begin
            if (directed_rows[n].known) begin
                exp.faces     = directed_rows[n].faces;
                exp.dice      = directed_rows[n].dice;
                exp.target    = directed_rows[n].target;
                exp.ways      = directed_rows[n].ways;
                exp.saturated = directed_rows[n].saturated;
            end else begin
                exp = count_dice_ways(directed_rows[n].faces, directed_rows[n].dice,
                                      directed_rows[n].target);
            end
            send_request(exp);
        end

        // random part: mostly small solvable requests, some edges and rejects
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (n == 30 || n == 60) begin
                // a couple of big requests
                f = $urandom_range(1, MAX_FACES);
                d = $urandom_range(16, MAX_DICE);
                t = $urandom_range(128, MAX_SUM);
            end else if (pick < 10) begin
                // rejected: one field forced past its limit, the rest anything
                f = $urandom_range(0, 63);
                d = $urandom_range(0, 63);
                t = $urandom_range(0, 511);
                case ($urandom_range(0, 2))
                    0: begin
                        f = $urandom_range(MAX_FACES + 1, 63);
                    end
                    1: begin
                        d = $urandom_range(MAX_DICE + 1, 63);
                    end
                    default: begin
                        t = $urandom_range(MAX_SUM + 1, 511);
                    end
                endcase
                // keep the big in-range fields away from a long run
                if (f <= MAX_FACES && d <= MAX_DICE && t <= MAX_SUM) t = MAX_SUM + 1;
            end else if (pick < 18) begin
                // zero dice, zero faces or zero target
                f = $urandom_range(0, MAX_FACES);
                d = $urandom_range(0, MAX_DICE);
                t = $urandom_range(0, MAX_SUM);
                case ($urandom_range(0, 2))
                    0: begin
                        d = 0;
                    end
                    1: begin
                        f = 0;
                    end
                    default: begin
                        t = 0;
                    end
                endcase
            end else begin
                f = $urandom_range(1, MAX_FACES);
                d = $urandom_range(1, 6);
                if (pick < 30) begin
                    t = $urandom_range(0, SMALL_SUM);
                end else begin
                    // inside the reachable range so most answers are nonzero
                    hi = (d * f < SMALL_SUM) ? d * f : SMALL_SUM;
                    t  = $urandom_range(d, hi);
                end
            end
            send_request(count_dice_ways(f, d, t));
        end

        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // response side backpressure, switching between always ready, coin flip and mostly stalled
    initial begin
        int unsigned mode;
        int unsigned left;
        mode          = 0;
        left          = 0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                0: begin
                    rsp_bus.ready <= 1'b1;
                end
                1: begin
                    rsp_bus.ready <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    rsp_bus.ready <= ($urandom_range(0, 4) == 0);
                end
            endcase
        end
    end

    // compare each response transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_dice_result exp;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("response with no request waiting: ways %0d sat %0b",
                                          rsp_bus.ways, rsp_bus.saturated));
            end else begin
                exp = pending_results.pop_front();
                if (rsp_bus.ways !== exp.ways) begin
                    report_mismatch($sformatf("ways faces %0d dice %0d target %0d: %0d vs %0d",
                                              exp.faces, exp.dice, exp.target,
                                              rsp_bus.ways, exp.ways));
                end
                if (rsp_bus.saturated !== exp.saturated) begin
                    report_mismatch($sformatf("sat faces %0d dice %0d target %0d: %0b vs %0b",
                                              exp.faces, exp.dice, exp.target,
                                              rsp_bus.saturated, exp.saturated));
                end
            end
        end
    end

    // hard stop, several times the slowest legal run
    initial begin
        #(40_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bcc_pkg.sv
rtl/core/bcc_if.sv
rtl/core/bounded_composition_counter.sv
sim/tb_bounded_composition_counter.sv
